>>> design/mclr_pkg.sv
package mclr_pkg;

    localparam int LINE_CAPACITY = 255;
    localparam int LINE_LEN_W    = $clog2(LINE_CAPACITY + 1);

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;

    localparam logic KIND_ARG = 1'b0;
    localparam logic KIND_EOL = 1'b1;

    localparam logic [3:0] CMD_UNKNOWN = 4'd0;
    localparam int         NUM_KEYWORDS = 10;

    // Keywords in command-code order; code is index plus one.
    localparam logic [31:0] KEYWORDS [NUM_KEYWORDS] = '{
        "USER", "PASS", "LIST", "STAT", "RSET",
        "DELE", "NOOP", "DATA", "RETR", "QUIT"
    };

    typedef struct packed {
        logic       kind;
        logic [7:0] arg_byte;
        logic [3:0] command;
        logic       has_argument;
        logic       overflow;
        logic       last;
    } result_t;

    // Up to two results produced by one input byte, first in output order.
    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } push_t;

    function automatic logic [3:0] command_code(logic [31:0] shift, logic [2:0] len);
        logic [3:0] code;
        code = CMD_UNKNOWN;
        if (len == 3'd4)
        begin
            for (int i = 0; i < NUM_KEYWORDS; i++)
            begin
                if (KEYWORDS[i] == shift)
                begin
                    code = 4'(i + 1);
                end
            end
        end
        return code;
    endfunction

    function automatic result_t arg_result(logic [7:0] b);
        result_t r;
        r              = '0;
        r.kind         = KIND_ARG;
        r.arg_byte     = b;
        return r;
    endfunction

endpackage

>>> design/mail_command_line_recognizer.sv
// Channel   Direction  tdata (low bit up)                               tuser  tlast
// s_axis    in         in_byte[7:0]                                     -      -
// m_axis    out        arg_byte[7:0] command[11:8] has_argument[12]     kind   last
//                      overflow[13] zero[15:14]
//
// One byte is taken per cycle while s_tready is high; its results are registered in
// the queue. A byte yields up to two results, buffered in a four-entry queue, and
// the output drains one result per cycle while m_tready is high.
// s_tready drops only while the queue lacks room for two results.
// Reset (rst_n, asynchronous, active low) empties the queue and starts a new line.
module mail_command_line_recognizer
    import mclr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // in_byte[7:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // arg_byte, command, has_argument, overflow, zero pad
    output logic        m_tuser,   // kind
    output logic        m_tlast
);

    push_t   push;
    result_t out_result;
    logic    accept;

    assign accept = s_tvalid & s_tready;

    mclr_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .in_byte (s_tdata),
        .push    (push)
    );

    mclr_out_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .room       (s_tready),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (out_result)
    );

    assign m_tdata = {2'b00, out_result.overflow, out_result.has_argument,
                      out_result.command, out_result.arg_byte};
    assign m_tuser = out_result.kind;
    assign m_tlast = out_result.last;

endmodule

>>> design/mclr_core.sv
module mclr_core
    import mclr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] in_byte,
    output push_t      push
);

    typedef enum logic [2:0] {
        PH_LEAD,
        PH_KEYWORD,
        PH_GAP,
        PH_ARG,
        PH_TAIL
    } phase_t;

    typedef struct packed {
        phase_t      phase;
        logic [31:0] shift;
        logic [2:0]  len;
        logic        arg_seen;
        logic        emit;
    } step_t;

    phase_t                phase_reg, phase_next;
    logic [31:0]           shift_reg, shift_next;
    logic [2:0]            kw_len_reg, kw_len_next;
    logic                  held_cr_reg, held_cr_next;
    logic                  arg_seen_reg, arg_seen_next;
    logic [LINE_LEN_W-1:0] line_len_reg, line_len_next;
    logic                  overflowed_reg, overflowed_next;

    step_t cur, after_cr, after_byte;
    logic  emit_cr, emit_byte;

    function automatic step_t add_keyword_char(step_t s, logic [7:0] b);
        step_t      r;
        logic [7:0] ub;
        r  = s;
        ub = (b >= 8'h61 && b <= 8'h7A) ? (b - 8'h20) : b;
        if (s.len < 3'd4)
        begin
            r.shift = {s.shift[23:0], ub};
            r.len   = s.len + 3'd1;
        end
        else
        begin
            r.len = 3'd5;
        end
        return r;
    endfunction

    function automatic step_t classify(step_t s, logic [7:0] b);
        step_t r;
        r      = s;
        r.emit = 1'b0;
        unique case (s.phase)
            PH_LEAD:
            begin
                if (b != CH_SPACE)
                begin
                    r       = add_keyword_char(r, b);
                    r.phase = PH_KEYWORD;
                end
            end
            PH_KEYWORD:
            begin
                if (b == CH_SPACE)
                begin
                    r.phase = PH_GAP;
                end
                else
                begin
                    r = add_keyword_char(r, b);
                end
            end
            PH_GAP:
            begin
                if (b != CH_SPACE)
                begin
                    r.phase    = PH_ARG;
                    r.arg_seen = 1'b1;
                    r.emit     = 1'b1;
                end
            end
            PH_ARG:
            begin
                if (b == CH_SPACE)
                begin
                    r.phase = PH_TAIL;
                end
                else
                begin
                    r.emit = 1'b1;
                end
            end
            default:
            begin
                r.emit = 1'b0;
            end
        endcase
        return r;
    endfunction

    always_comb
    begin
        cur        = '{phase_reg, shift_reg, kw_len_reg, arg_seen_reg, 1'b0};
        after_cr   = held_cr_reg ? classify(cur, CH_CR) : cur;
        after_byte = (in_byte != CH_CR) ? classify(after_cr, in_byte) : after_cr;
        emit_cr    = held_cr_reg & after_cr.emit;
        emit_byte  = (in_byte != CH_CR) & after_byte.emit;

        phase_next      = phase_reg;
        shift_next      = shift_reg;
        kw_len_next     = kw_len_reg;
        held_cr_next    = held_cr_reg;
        arg_seen_next   = arg_seen_reg;
        line_len_next   = line_len_reg;
        overflowed_next = overflowed_reg;
        push            = '0;

        if (accept)
        begin
            if (in_byte == CH_LF)
            begin
                // End of line: report and start the next line from scratch.
                push.count              = 2'd1;
                push.first.kind         = KIND_EOL;
                push.first.command      = command_code(shift_reg, kw_len_reg);
                push.first.has_argument = arg_seen_reg;
                push.first.overflow     = overflowed_reg;
                push.first.last         = 1'b1;
                phase_next      = PH_LEAD;
                shift_next      = '0;
                kw_len_next     = '0;
                held_cr_next    = 1'b0;
                arg_seen_next   = 1'b0;
                line_len_next   = '0;
                overflowed_next = 1'b0;
            end
            else if (line_len_reg >= LINE_LEN_W'(LINE_CAPACITY))
            begin
                overflowed_next = 1'b1;
            end
            else
            begin
                line_len_next = line_len_reg + 1'b1;
                held_cr_next  = (in_byte == CH_CR);
                phase_next    = after_byte.phase;
                shift_next    = after_byte.shift;
                kw_len_next   = after_byte.len;
                arg_seen_next = after_byte.arg_seen;
                push.count    = {1'b0, emit_cr} + {1'b0, emit_byte};
                push.first    = emit_cr ? arg_result(CH_CR) : arg_result(in_byte);
                push.second   = arg_result(in_byte);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_LEAD;
            shift_reg      <= '0;
            kw_len_reg     <= '0;
            held_cr_reg    <= 1'b0;
            arg_seen_reg   <= 1'b0;
            line_len_reg   <= '0;
            overflowed_reg <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            shift_reg      <= shift_next;
            kw_len_reg     <= kw_len_next;
            held_cr_reg    <= held_cr_next;
            arg_seen_reg   <= arg_seen_next;
            line_len_reg   <= line_len_next;
            overflowed_reg <= overflowed_next;
        end
    end

endmodule

>>> design/mclr_out_queue.sv
module mclr_out_queue
    import mclr_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  push_t   push,
    output logic    room,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_result
);

    result_t               mem_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CW-1:0]   count_reg, count_next;
    logic                  pop;

    // Room for the worst case of two results from one byte.
    assign room       = (count_reg <= QUEUE_CW'(QUEUE_DEPTH - 2));
    assign out_valid  = (count_reg != '0);
    assign out_result = mem_reg[rd_ptr_reg];
    assign pop        = out_valid & out_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + QUEUE_AW'(push.count);
        rd_ptr_next = rd_ptr_reg + QUEUE_AW'(pop);
        count_next  = count_reg + QUEUE_CW'(push.count) - QUEUE_CW'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            mem_reg[wr_ptr_reg + 1'b1] <= push.second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule
